[hw/rtl/mfs_pkg.sv]
package mfs_pkg;

    localparam int unsigned ITEM_W = 117;
    localparam int unsigned RES_W  = 15;

    localparam logic [31:0] LOW_VOLTAGE_HOLD_MS   = 32'd10000;
    localparam logic [7:0]  MIN_RECOVERY_MESSAGES = 8'd3;
    localparam logic [3:0]  ASCENT_CODE           = 4'd3;
    localparam logic [3:0]  SURFACE_CODE          = 4'd4;

    typedef enum logic [1:0] {
        MODE_PREDIVE  = 2'd0,
        MODE_DIVING   = 2'd1,
        MODE_RECOVERY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE   = 3'd0,
        CAUSE_LOWV   = 3'd1,
        CAUSE_LEAK   = 3'd2,
        CAUSE_NO_HB  = 3'd3,
        CAUSE_MANUAL = 3'd4,
        CAUSE_REMOTE = 3'd5
    } cause_t;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_DIVE    = 4'd1,
        CMD_RECOVER = 4'd2,
        CMD_RESET   = 4'd3,
        CMD_MANUAL  = 4'd4,
        CMD_REMOTE  = 4'd5,
        CMD_ACK     = 4'd6,
        CMD_REL_ON  = 4'd7,
        CMD_REL_OFF = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DIVE_GRACE   = 3'd0,
        REG_CRIT_MV      = 3'd1,
        REG_HB_TIMEOUT   = 3'd2,
        REG_DWELL        = 3'd3,
        REG_FINAL_GRACE  = 3'd4,
        REG_RECOV_DEPTH  = 3'd5,
        REG_LIVENESS     = 3'd6,
        REG_QUALIFY      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]        dive_grace_ms;
        logic [15:0]        critical_voltage_mv;
        logic [31:0]        heartbeat_timeout_ms;
        logic [31:0]        surface_dwell_ms;
        logic [31:0]        final_grace_ms;
        logic signed [15:0] recovery_depth_cm;
        logic [15:0]        depth_liveness_cm;
        logic [31:0]        window_hold_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dive_grace_ms:        32'd60000,
        critical_voltage_mv:  16'd13200,
        heartbeat_timeout_ms: 32'd30000,
        surface_dwell_ms:     32'd60000,
        final_grace_ms:       32'd30000,
        recovery_depth_cm:    16'sd100,
        depth_liveness_cm:    16'd10,
        window_hold_ms:       32'd30000
    };

    // first member lands in the highest bits
    typedef struct packed {
        logic signed [15:0] depth_cm;
        logic               depth_ok;
        logic [7:0]         recovery_messages;
        logic               mission_state_fresh;
        logic [3:0]         mission_state;
        logic [31:0]        heartbeat_seen_ms;
        logic               had_heartbeat;
        logic [15:0]        battery_mv;
        logic               voltage_fresh;
        logic               leak;
        logic [31:0]        now_ms;
        logic [3:0]         command;
    } item_t;

    typedef struct packed {
        logic       backstop_fired;
        logic       shutdown_acked;
        logic       shutdown_wanted;
        logic       surface_ok;
        logic       nonessentials_on;
        logic       command_accepted;
        logic       release_off_request;
        logic       release_request;
        logic [2:0] failsafe_cause;
        logic [1:0] prior_mode;
        logic [1:0] mode;
    } result_t;

    typedef struct packed {
        mode_t              cur_mode;
        mode_t              prev_mode;
        logic [31:0]        entry_time;
        cause_t             cause;
        logic               power;
        logic               qualified;
        logic               request;
        logic               ack;
        logic [31:0]        ack_time;
        logic [31:0]        dwell_start;
        logic               dwell_active;
        logic [31:0]        lowv_start;
        logic               lowv_active;
        logic [31:0]        window_start;
        logic signed [15:0] window_min;
        logic signed [15:0] window_max;
        logic               window_active;
    } state_t;

    localparam state_t ST_RESET = '{
        cur_mode:      MODE_PREDIVE,
        prev_mode:     MODE_PREDIVE,
        entry_time:    32'd0,
        cause:         CAUSE_NONE,
        power:         1'b1,
        qualified:     1'b0,
        request:       1'b0,
        ack:           1'b0,
        ack_time:      32'd0,
        dwell_start:   32'd0,
        dwell_active:  1'b0,
        lowv_start:    32'd0,
        lowv_active:   1'b0,
        window_start:  32'd0,
        window_min:    16'sd0,
        window_max:    16'sd0,
        window_active: 1'b0
    };

    function automatic state_t mfs_go_mode(state_t s, mode_t m, logic [31:0] now);
        state_t r;
        r = s;
        if (m != s.cur_mode) begin
            r.prev_mode  = s.cur_mode;
            r.cur_mode   = m;
            r.entry_time = now;
            r.power      = 1'b1;
            if (m != MODE_RECOVERY) begin
                r.qualified    = 1'b0;
                r.request      = 1'b0;
                r.ack          = 1'b0;
                r.ack_time     = 32'd0;
                r.dwell_start  = 32'd0;
                r.dwell_active = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic mfs_fs_takes(state_t s, cause_t c);
        return (s.cur_mode == MODE_DIVING) || (c == CAUSE_MANUAL) || (c == CAUSE_REMOTE);
    endfunction

    function automatic state_t mfs_failsafe(state_t s, cause_t c, logic [31:0] now);
        state_t r;
        r = s;
        if (mfs_fs_takes(s, c)) begin
            r.cause = c;
            if (s.cur_mode == MODE_DIVING) begin
                r = mfs_go_mode(r, MODE_RECOVERY, now);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/mission_failsafe_supervisor.sv]
// channel   direction  beat contents
// s_*       in         one tick: command, time, telemetry and depth snapshot
// m_*       out        one result per tick: mode, cause, requests, power state
// cfg_*     in         register write, index and data, no read-back
//
// One beat per cycle sustained while m_tready holds. A tick goes from the input
// register to the result register, which drives m_tdata, and the supervisor
// state updates with that move. Reset (aresetn low, synchronous)
// loads register defaults, pre-dive mode and power on. A held m_ beat stops that
// move, and s_tready drops only once the input register is full as well.
module mission_failsafe_supervisor
    import mfs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command, now_ms, leak, voltage_fresh, battery_mv, had_heartbeat,
    // heartbeat_seen_ms, mission_state, mission_state_fresh,
    // recovery_messages, depth_ok, depth_cm
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mode, prior_mode, failsafe_cause, release_request, release_off_request,
    // command_accepted, nonessentials_on, surface_ok, shutdown_wanted,
    // shutdown_acked, backstop_fired
    output logic [15:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res;
    logic    advance;
    logic    take;

    mfs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mfs_step u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .item    (in_reg),
        .st_next (st_next),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= ST_RESET;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: capture on the beat, no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            in_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    a_backstop_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.backstop_fired |-> out_reg.mode == MODE_RECOVERY)
        else $error("backstop fired without recovery mode");

    a_power_cut_acked: assert property (@(posedge aclk) disable iff (!aresetn)
        !st_reg.power |-> st_reg.ack)
        else $error("power cut without acknowledgement");

    a_request_qualified: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.request |-> st_reg.qualified)
        else $error("shutdown wanted while not qualified");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("state moved without a tick");

endmodule

[hw/rtl/mfs_cfg.sv]
module mfs_cfg
    import mfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DIVE_GRACE:  cfg_next.dive_grace_ms        = cfg_wdata;
                REG_CRIT_MV:     cfg_next.critical_voltage_mv  = cfg_wdata[15:0];
                REG_HB_TIMEOUT:  cfg_next.heartbeat_timeout_ms = cfg_wdata;
                REG_DWELL:       cfg_next.surface_dwell_ms     = cfg_wdata;
                REG_FINAL_GRACE: cfg_next.final_grace_ms       = cfg_wdata;
                REG_RECOV_DEPTH: cfg_next.recovery_depth_cm    = $signed(cfg_wdata[15:0]);
                REG_LIVENESS:    cfg_next.depth_liveness_cm    = cfg_wdata[15:0];
                REG_QUALIFY:     cfg_next.window_hold_ms       = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/mfs_step.sv]
module mfs_step
    import mfs_pkg::*;
(
    input  state_t  st,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    state_t             s;
    logic               rel;
    logic               rel_off;
    logic               acc;
    logic               fired;
    logic               crit;
    logic               done;
    logic               ascending;
    logic               shallow;
    logic               qnow;
    logic signed [16:0] spread;
    logic [31:0]        now;

    assign now = item.now_ms;

    always_comb begin
        s         = st;
        rel       = 1'b0;
        rel_off   = 1'b0;
        acc       = 1'b0;
        fired     = 1'b0;
        crit      = 1'b0;
        done      = 1'b0;
        ascending = 1'b0;
        shallow   = 1'b0;
        qnow      = 1'b0;
        spread    = '0;

        // command
        unique case (item.command)
            CMD_DIVE: begin
                if (s.cur_mode == MODE_PREDIVE) begin
                    s = mfs_go_mode(s, MODE_DIVING, now);
                end
            end
            CMD_RECOVER: begin
                s = mfs_go_mode(s, MODE_RECOVERY, now);
            end
            CMD_RESET: begin
                s.cause = CAUSE_NONE;
                s = mfs_go_mode(s, MODE_PREDIVE, now);
            end
            CMD_MANUAL: begin
                rel = 1'b1;
                s = mfs_failsafe(s, CAUSE_MANUAL, now);
            end
            CMD_REMOTE: begin
                rel = 1'b1;
                s = mfs_failsafe(s, CAUSE_REMOTE, now);
            end
            CMD_ACK: begin
                if (s.request && s.qualified) begin
                    if (!s.ack) begin
                        s.ack      = 1'b1;
                        s.ack_time = now;
                    end
                    acc = 1'b1;
                end
            end
            CMD_REL_ON: begin
                rel = 1'b1;
                acc = 1'b1;
            end
            CMD_REL_OFF: begin
                rel_off = s.qualified;
                acc     = s.qualified;
            end
            default: begin
            end
        endcase

        // failsafe checks
        if (s.cur_mode != MODE_DIVING || 32'(now - s.entry_time) < cfg.dive_grace_ms) begin
            s.lowv_active = 1'b0;
        end else if (item.leak) begin
            rel = 1'b1;
            s = mfs_failsafe(s, CAUSE_LEAK, now);
        end else begin
            crit = item.voltage_fresh && (item.battery_mv != 16'd0) &&
                   (item.battery_mv <= cfg.critical_voltage_mv);
            if (crit) begin
                if (!s.lowv_active) begin
                    s.lowv_start  = now;
                    s.lowv_active = 1'b1;
                end
                if (32'(now - s.lowv_start) >= LOW_VOLTAGE_HOLD_MS) begin
                    rel  = 1'b1;
                    s    = mfs_failsafe(s, CAUSE_LOWV, now);
                    done = 1'b1;
                end
            end else begin
                s.lowv_active = 1'b0;
            end
            if (!done && item.had_heartbeat &&
                32'(now - item.heartbeat_seen_ms) >= cfg.heartbeat_timeout_ms) begin
                rel = 1'b1;
                s = mfs_failsafe(s, CAUSE_NO_HB, now);
            end
        end

        // depth backstop
        ascending = (s.cur_mode == MODE_DIVING) && (item.mission_state >= ASCENT_CODE);
        shallow   = item.depth_ok && (item.depth_cm < cfg.recovery_depth_cm);
        if (!ascending || !shallow) begin
            s.window_start  = 32'd0;
            s.window_min    = 16'sd0;
            s.window_max    = 16'sd0;
            s.window_active = 1'b0;
        end else begin
            if (!s.window_active) begin
                s.window_active = 1'b1;
                s.window_start  = now;
                s.window_min    = item.depth_cm;
                s.window_max    = item.depth_cm;
            end else begin
                if (item.depth_cm < s.window_min) begin
                    s.window_min = item.depth_cm;
                end
                if (item.depth_cm > s.window_max) begin
                    s.window_max = item.depth_cm;
                end
            end
            spread = 17'(s.window_max) - 17'(s.window_min);
            if (spread >= $signed({1'b0, cfg.depth_liveness_cm}) &&
                32'(now - s.window_start) >= cfg.window_hold_ms) begin
                s.window_start  = 32'd0;
                s.window_min    = 16'sd0;
                s.window_max    = 16'sd0;
                s.window_active = 1'b0;
                s = mfs_go_mode(s, MODE_RECOVERY, now);
                fired = 1'b1;
            end
        end

        // surface shutdown
        if (s.ack) begin
            if (32'(now - s.ack_time) >= cfg.final_grace_ms) begin
                s.power = 1'b0;
            end
        end else begin
            qnow = (s.cur_mode == MODE_RECOVERY) && (s.prev_mode == MODE_DIVING) &&
                   item.mission_state_fresh && (item.mission_state == SURFACE_CODE) &&
                   (item.recovery_messages >= MIN_RECOVERY_MESSAGES);
            if (!qnow) begin
                s.dwell_start  = 32'd0;
                s.dwell_active = 1'b0;
                s.qualified    = 1'b0;
                s.request      = 1'b0;
            end else begin
                s.qualified = 1'b1;
                if (!s.dwell_active) begin
                    s.dwell_start  = now;
                    s.dwell_active = 1'b1;
                end
                s.request = 32'(now - s.dwell_start) >= cfg.surface_dwell_ms;
            end
        end
    end

    assign st_next                 = s;
    assign res.mode                = s.cur_mode;
    assign res.prior_mode          = s.prev_mode;
    assign res.failsafe_cause      = s.cause;
    assign res.release_request     = rel;
    assign res.release_off_request = rel_off;
    assign res.command_accepted    = acc;
    assign res.nonessentials_on    = s.power;
    assign res.surface_ok          = s.qualified;
    assign res.shutdown_wanted     = s.request;
    assign res.shutdown_acked      = s.ack;
    assign res.backstop_fired      = fired;

endmodule
